@@ src/ffa_pkg.sv @@
// Shared types and codes for the first-fit address range allocator.
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int unsigned PAGE_W = 33;
  localparam int unsigned SIZE_W = 34;
  // The window holds 2^WINDOW_PAGE_BITS pages; the page and size widths are set by hand to match it.
  localparam int unsigned WINDOW_PAGE_BITS = 33;

  typedef enum logic [1:0] {
    FN_RESERVE = 2'd0,
    FN_FREE    = 2'd1,
    FN_FREE_IO = 2'd2,
    FN_LOOKUP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;     // latch the request, clear cursor and index
    logic    idx_clr;
    logic    idx_inc;
    logic    cur_upd;  // cursor <= end of current entry
    logic    ins;      // insert new area at current index
    logic    rem;      // remove entry at current index
    logic    rsp;      // register a result
    status_t rsp_code;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    func_t func;
    logic  size_zero;
    logic  full;
    logic  idx_end;   // index has passed the last valid entry
    logic  gap_fit;   // gap before current entry holds the size
    logic  start_lt;  // current entry starts below the cursor
    logic  hit;       // current entry holds the page
    logic  io;        // mark of current entry
    logic  space_ok;  // window tail from cursor holds the size
  } sts_t;

endpackage

@@ src/ffa_ctrl.sv @@
// Request sequencer of the allocator.
`timescale 1ns / 1ps
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_GAP, S_POS, S_FIND} state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.rsp_code = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.func == FN_RESERVE) begin
          if (sts.size_zero) begin
            cmd.rsp = 1'b1; cmd.rsp_code = ST_ZERO; state_next = S_IDLE;
          end else if (sts.full) begin
            cmd.rsp = 1'b1; cmd.rsp_code = ST_FULL; state_next = S_IDLE;
          end else begin
            state_next = S_GAP;
          end
        end else begin
          state_next = S_FIND;
        end
      end
      S_GAP: begin
        if (sts.idx_end || sts.gap_fit) begin
          if (!sts.space_ok) begin
            cmd.rsp = 1'b1; cmd.rsp_code = ST_NOSPACE; state_next = S_IDLE;
          end else begin
            cmd.idx_clr = 1'b1; state_next = S_POS;
          end
        end else begin
          cmd.cur_upd = 1'b1; cmd.idx_inc = 1'b1;
        end
      end
      S_POS: begin
        if (sts.idx_end || !sts.start_lt) begin
          cmd.ins = 1'b1; cmd.rsp = 1'b1; cmd.rsp_code = ST_OK; state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FIND: begin
        if (sts.idx_end) begin
          cmd.rsp = 1'b1; cmd.rsp_code = ST_NOTFOUND; state_next = S_IDLE;
        end else if (sts.hit) begin
          cmd.rsp = 1'b1;
          state_next = S_IDLE;
          if (sts.func == FN_FREE_IO && !sts.io) begin
            cmd.rsp_code = ST_NOTFOUND;
          end else begin
            cmd.rsp_code = ST_OK;
            cmd.rem = (sts.func != FN_LOOKUP);
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ src/ffa_dp.sv @@
// Area table, scan index, cursor and result registers.
`timescale 1ns / 1ps
module ffa_dp
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_AREAS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        func,
  input  logic [SIZE_W-1:0] size_pages,
  input  logic [PAGE_W-1:0] page_addr,
  input  logic              is_io,
  output logic              done,
  output logic [2:0]        status,
  output logic [PAGE_W-1:0] area_page,
  output logic [PAGE_W-1:0] page_index,
  output logic              area_is_io
);

  localparam int unsigned AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_AREAS + 1);
  localparam int unsigned CW = (WINDOW_PAGE_BITS + 1 > SIZE_W + 1) ?
                               WINDOW_PAGE_BITS + 1 : SIZE_W + 1;
  localparam logic [CW-1:0] WIN = CW'(1) << WINDOW_PAGE_BITS;

  logic [PAGE_W-1:0] slot_start [MAX_AREAS];
  logic [SIZE_W-1:0] slot_end   [MAX_AREAS];
  logic              slot_io    [MAX_AREAS];
  logic [CNTW-1:0]   used_slots;

  logic [CNTW-1:0]   idx;
  logic [CW-1:0]     cursor;
  func_t             req_func;
  logic [SIZE_W-1:0] req_size;
  logic [PAGE_W-1:0] req_page;
  logic              req_io;

  logic [AW-1:0]     ia;
  logic [CW-1:0]     e_start, e_end, size_x, end_new;

  assign ia      = idx[AW-1:0];
  assign e_start = CW'(slot_start[ia]);
  assign e_end   = CW'(slot_end[ia]);
  assign size_x  = CW'(req_size);
  assign end_new = cursor + size_x;

  always_comb begin
    sts.func      = req_func;
    sts.size_zero = (req_size == '0);
    sts.full      = (used_slots >= CNTW'(MAX_AREAS));
    sts.idx_end   = (idx >= used_slots);
    sts.gap_fit   = (e_start > cursor) && ((e_start - cursor) >= size_x);
    sts.start_lt  = (e_start < cursor);
    sts.hit       = (req_page >= slot_start[ia]) &&
                    ({1'b0, req_page} < slot_end[ia]);
    sts.io        = slot_io[ia];
    sts.space_ok  = (cursor <= WIN) && ((WIN - cursor) >= size_x);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= func_t'(func);
      req_size <= size_pages;
      req_page <= page_addr;
      req_io   <= is_io;
      cursor   <= '0;
    end else if (cmd.cur_upd) begin
      cursor <= e_end;
    end
    if (cmd.load || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Table: shifts read only the neighboring entry.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_AREAS; j++) begin
      if (cmd.ins) begin
        if (CNTW'(j) == idx) begin
          slot_start[j] <= cursor[PAGE_W-1:0];
          slot_end[j]   <= end_new[SIZE_W-1:0];
          slot_io[j]    <= req_io;
        end else if (j > 0 && CNTW'(j) > idx) begin
          slot_start[j] <= slot_start[(j > 0) ? j - 1 : 0];
          slot_end[j]   <= slot_end[(j > 0) ? j - 1 : 0];
          slot_io[j]    <= slot_io[(j > 0) ? j - 1 : 0];
        end
      end else if (cmd.rem) begin
        if (j + 1 < MAX_AREAS && CNTW'(j) >= idx) begin
          slot_start[j] <= slot_start[(j + 1 < MAX_AREAS) ? j + 1 : j];
          slot_end[j]   <= slot_end[(j + 1 < MAX_AREAS) ? j + 1 : j];
          slot_io[j]    <= slot_io[(j + 1 < MAX_AREAS) ? j + 1 : j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.rsp;
      if (cmd.ins) begin
        used_slots <= used_slots + 1'b1;
      end else if (cmd.rem) begin
        used_slots <= used_slots - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp) begin
      status     <= cmd.rsp_code;
      area_page  <= '0;
      page_index <= '0;
      area_is_io <= 1'b0;
      if (cmd.rsp_code == ST_OK) begin
        if (req_func == FN_RESERVE) begin
          area_page  <= cursor[PAGE_W-1:0];
          area_is_io <= req_io;
        end else begin
          area_page  <= slot_start[ia];
          area_is_io <= slot_io[ia];
          if (req_func == FN_LOOKUP) begin
            page_index <= req_page - slot_start[ia];
          end
        end
      end
    end
  end

  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNTW'(MAX_AREAS)) else $error("used_slots above table depth");
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> used_slots == $past(used_slots) + 1'b1) else $error("insert lost");
  a_rem_shrink: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |=> used_slots == $past(used_slots) - 1'b1) else $error("remove lost");
  a_rsp_done: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp |=> done) else $error("result not strobed");

endmodule

@@ src/first_fit_address_range_allocator_top.sv @@
// Top level of the first-fit address range allocator.
`timescale 1ns / 1ps
// Reserve scans the table for a gap and then for the insert position; free/lookup scan once;
//   the table scan advances one entry per cycle in the controller loop.
// Throughput: one item at a time; busy stays high until the result is registered.
// done pulses one cycle with the result; the receiver cannot stall it.
// Reset clears the area count and the controller; table contents need no clear.
module first_fit_address_range_allocator_top
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_AREAS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [SIZE_W-1:0] size_pages,
  input  logic [PAGE_W-1:0] page_addr,
  input  logic              is_io,
  output logic              done,
  output logic [2:0]        status,
  output logic [PAGE_W-1:0] area_page,
  output logic [PAGE_W-1:0] page_index,
  output logic              area_is_io
);

  // Commands flow down, status flags flow back up.
  cmd_t cmd;
  sts_t sts;

  // Sequence each item: decide, then scan for a gap and find the slot (reserve) or search for the area, respond.
  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the sorted area table and drive the result registers.
  ffa_dp #(
    .MAX_AREAS (MAX_AREAS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .size_pages (size_pages),
    .page_addr  (page_addr),
    .is_io      (is_io),
    .done       (done),
    .status     (status),
    .area_page  (area_page),
    .page_index (page_index),
    .area_is_io (area_is_io)
  );

endmodule

@@ tb/first_fit_address_range_allocator_top_tb.sv @@
// Testbench for the first-fit address range allocator: directed and random requests.
`timescale 1ns / 1ps
module first_fit_address_range_allocator_top_tb;
  import ffa_pkg::*;

  localparam int unsigned AREAS = 16;
  localparam logic [SIZE_W-1:0] WIN_PAGES = 34'h2_0000_0000;

  typedef struct packed {
    status_t           st;
    logic [PAGE_W-1:0] area;
    logic [PAGE_W-1:0] idx;
    logic              io;
  } alloc_rsp_t;

  // Scoreboard: mirror the area table and queue one expected result per request.
  class area_table_sb;
    logic [PAGE_W-1:0] a_start[AREAS];
    logic [SIZE_W-1:0] a_end[AREAS];
    logic              a_io[AREAS];
    int                n_used;
    alloc_rsp_t        pending[$];
    int                errors;

    function new();
      n_used = 0;
      errors = 0;
    endfunction

    // Predict the result of an accepted request and update the mirror.
    function void note_request(func_t f, logic [SIZE_W-1:0] sz,
                               logic [PAGE_W-1:0] pg, logic io);
      alloc_rsp_t r;
      logic [SIZE_W-1:0] cur;
      int i, k, pos;
      r = '{ST_OK, '0, '0, 1'b0};
      if (f == FN_RESERVE) begin
        if (sz == 0) r.st = ST_ZERO;
        else if (n_used >= AREAS) r.st = ST_FULL;
        else begin
          cur = 0;
          for (i = 0; i < n_used; i++) begin
            if ({1'b0, a_start[i]} > cur && {1'b0, a_start[i]} - cur >= sz) break;
            cur = a_end[i];
          end
          if (cur > WIN_PAGES || WIN_PAGES - cur < sz) r.st = ST_NOSPACE;
          else begin
            pos = 0;
            while (pos < n_used && {1'b0, a_start[pos]} < cur) pos++;
            for (i = n_used; i > pos; i--) begin
              a_start[i] = a_start[i-1];
              a_end[i] = a_end[i-1];
              a_io[i] = a_io[i-1];
            end
            a_start[pos] = cur[PAGE_W-1:0];
            a_end[pos] = cur + sz;
            a_io[pos] = io;
            n_used++;
            r.area = cur[PAGE_W-1:0];
            r.io = io;
          end
        end
      end else begin
        k = n_used;
        for (i = 0; i < n_used; i++)
          if (pg >= a_start[i] && {1'b0, pg} < a_end[i]) begin
            k = i;
            break;
          end
        if (k >= n_used || (f == FN_FREE_IO && !a_io[k])) r.st = ST_NOTFOUND;
        else begin
          r.area = a_start[k];
          r.io = a_io[k];
          if (f == FN_LOOKUP) r.idx = pg - a_start[k];
          else begin
            for (i = k; i + 1 < n_used; i++) begin
              a_start[i] = a_start[i+1];
              a_end[i] = a_end[i+1];
              a_io[i] = a_io[i+1];
            end
            n_used--;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [PAGE_W-1:0] area,
                               logic [PAGE_W-1:0] idx, logic io);
      alloc_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d area=%0h", st, area);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st); errors++;
      end
      if (area !== e.area) begin
        $error("area_page: expected %0h, got %0h", e.area, area); errors++;
      end
      if (idx !== e.idx) begin
        $error("page_index: expected %0h, got %0h", e.idx, idx); errors++;
      end
      if (io !== e.io) begin
        $error("area_is_io: expected %0b, got %0b", e.io, io); errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        func = '0;
  logic [SIZE_W-1:0] size_pages = '0;
  logic [PAGE_W-1:0] page_addr = '0;
  logic              is_io = 1'b0;
  logic              done;
  logic [2:0]        status;
  logic [PAGE_W-1:0] area_page;
  logic [PAGE_W-1:0] page_index;
  logic              area_is_io;

  area_table_sb sb = new();
  bit quiet_stretch;   // no idle gaps while set

  first_fit_address_range_allocator_top uut (
    .clk, .rst, .start, .busy, .func, .size_pages, .page_addr, .is_io,
    .done, .status, .area_page, .page_index, .area_is_io
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each result on the edge that accepts it.
  always @(posedge clk)
    if (!rst && done) sb.check_result(status, area_page, page_index, area_is_io);

  // Drive one request; hold start until the block accepts the item.
  // Start stays high between items unless an idle gap is taken.
  task automatic issue(func_t f, logic [SIZE_W-1:0] sz, logic [PAGE_W-1:0] pg,
                       logic io);
    bit accepted;
    // Idle for a while about 38 times in a hundred, unless in the quiet stretch.
    if (!quiet_stretch && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
      while (!quiet_stretch && $urandom_range(99) < 38) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    size_pages <= sz;
    page_addr <= pg;
    is_io <= io;
    accepted = 0;
    while (!accepted) begin
      @(posedge clk);
      if (!busy) begin
        accepted = 1;
        sb.note_request(f, sz, pg, io);
      end
    end
  endtask

  // Random page: mostly near held areas, sometimes anywhere.
  function automatic logic [PAGE_W-1:0] pick_page();
    int k;
    if (sb.n_used > 0 && $urandom_range(9) < 7) begin
      k = $urandom_range(sb.n_used - 1);
      return sb.a_start[k] + $urandom_range(3) - (($urandom_range(7) == 0) ? 1 : 0);
    end
    return PAGE_W'({$urandom, $urandom});
  endfunction

  // Random size: mostly small, a few huge ones to reach the window limit.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(19))
      0: return SIZE_W'({$urandom, $urandom});
      1: return '0;
      2: return WIN_PAGES - $urandom_range(3);
      default: return SIZE_W'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int i;
    func_t f;
    quiet_stretch = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero size, lookups on an empty table, window extremes.
    issue(FN_RESERVE, '0, '0, 1'b0);
    issue(FN_LOOKUP, '0, '0, 1'b0);
    issue(FN_FREE, '0, '1, 1'b0);
    issue(FN_RESERVE, WIN_PAGES + 1, '0, 1'b1);
    issue(FN_RESERVE, '1, '0, 1'b1);
    issue(FN_RESERVE, WIN_PAGES, '0, 1'b1);
    issue(FN_LOOKUP, '0, '1, 1'b0);
    issue(FN_FREE_IO, '0, 33'h1_2345_6789, 1'b0);
    issue(FN_RESERVE, 34'd1, '0, 1'b0);
    issue(FN_RESERVE, 34'd5, '0, 1'b1);
    issue(FN_FREE_IO, '0, 33'd0, 1'b0);    // plain area kept
    issue(FN_LOOKUP, '0, 33'd4, 1'b0);
    issue(FN_FREE, '0, 33'd0, 1'b0);       // opens a hole at page 0
    issue(FN_RESERVE, 34'd1, '0, 1'b1);    // fills the hole
    issue(FN_FREE_IO, '0, 33'd3, 1'b0);
    // Fill the table, then overflow it.
    for (i = 0; i < AREAS + 1; i++) issue(FN_RESERVE, 34'd2, '0, i[0]);
    issue(FN_RESERVE, 34'd1, '0, 1'b0);
    for (i = 0; i < AREAS; i++) issue(FN_FREE, '0, sb.a_start[0], 1'b0);

    // Random: weighted toward reserve/free so the table churns.
    for (i = 0; i < 400; i++) begin
      quiet_stretch = (i >= 150 && i < 220);
      case ($urandom_range(9))
        0, 1, 2, 3: f = FN_RESERVE;
        4, 5: f = FN_FREE;
        6, 7: f = FN_FREE_IO;
        default: f = FN_LOOKUP;
      endcase
      issue(f, pick_size(), pick_page(), $urandom_range(1));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/ffa_pkg.sv
src/ffa_ctrl.sv
src/ffa_dp.sv
src/first_fit_address_range_allocator_top.sv
tb/first_fit_address_range_allocator_top_tb.sv
